[sv/apr_pkg.sv]
// shared types, constants and helpers for the adaptive packet redundancy block
// no dependencies; every other file imports this package
`default_nettype none

package apr_pkg;

	localparam int NUM_PEERS  = 8;
	localparam int PEER_IDX_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;

	localparam int FUNC_W     = 2;
	localparam int PEER_W     = 4;
	localparam int TICK_W     = 32;
	localparam int ID_W       = 32;
	localparam int KIND_W     = 2;
	localparam int COPIES_W   = 2;
	localparam int GAUGE_W    = 15;
	localparam int DUP_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 56;

	localparam logic [GAUGE_W-1:0] RESEND_BUMP = 15'd4000;
	localparam logic [GAUGE_W-1:0] GAUGE_CAP   = 15'd20000;
	localparam logic [GAUGE_W-1:0] GAP_BUMP    = 15'd500;
	localparam logic [ID_W-1:0]    GAP_RUN_CAP = 32'd3;

	localparam logic [COPIES_W-1:0] COPIES_ONE = 2'd1;
	localparam logic [COPIES_W-1:0] COPIES_TWO = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RESEND  = 2'd0,
		FUNC_INBOUND = 2'd1,
		FUNC_DECIDE  = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	localparam logic [KIND_W-1:0] KIND_RELIABLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACK      = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED    = 2'd0,
		CFG_COPY_COUNT = 2'd1,
		CFG_ADAPTIVE   = 2'd2,
		CFG_DUP_ACKS   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic stage;
		logic commit;
	} apr_cmd_t;

	function automatic logic [GAUGE_W-1:0] gap_amount(input logic [1:0] run);
		logic [GAUGE_W-1:0] amt;
		unique case (run)
			2'd1:    amt = GAP_BUMP;
			2'd2:    amt = 15'd1000;
			2'd3:    amt = 15'd1500;
			default: amt = '0;
		endcase
		return amt;
	endfunction

endpackage

`default_nettype wire

[sv/apr_ctrl.sv]
// sequencing controller: accept, decay stage, commit and output valid
// depends on apr_pkg for the command struct
`default_nettype none

module apr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output apr_pkg::apr_cmd_t     cmd
);
	import apr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DECAY = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nx    = state_q;
		cmd.capture = 1'b0;
		cmd.stage   = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_DECAY;
				end
			end
			ST_DECAY: begin
				cmd.stage = 1'b1;
				state_nx  = ST_APPLY;
			end
			ST_APPLY: begin
				if (!out_valid_q || m_tready) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= cmd.commit | (out_valid_q & ~m_tready);
		end
	end

`ifndef SYNTH
	a_accept_to_decay: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DECAY))
		else $error("accepted beat did not start the decay stage");
	a_decay_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECAY) |=> (state_q == ST_APPLY))
		else $error("decay stage not followed by apply");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

[sv/apr_dp.sv]
// datapath: config registers, per-peer gauge and sequence state, two-step update
// depends on apr_pkg; driven by apr_ctrl commands
`default_nettype none

module apr_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire apr_pkg::apr_cmd_t               cmd,
	input  wire logic                            cfg_we,
	input  wire logic [apr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [apr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [apr_pkg::FUNC_W-1:0]      in_func,
	input  wire logic [apr_pkg::S_TDATA_W-1:0]   in_data,
	output logic      [apr_pkg::M_TDATA_W-1:0]   out_data
);
	import apr_pkg::*;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_BUMP   = 2'd1,
		OP_REFUND = 2'd2,
		OP_DECIDE = 2'd3
	} op_t;

	// configuration
	logic                cfg_enabled_q, cfg_adaptive_q, cfg_dup_acks_q;
	logic [COPIES_W-1:0] cfg_copy_q;

	// captured beat
	func_t              func_q;
	logic [PEER_W-1:0]  peer_q;
	logic [TICK_W-1:0]  now_q;
	logic [ID_W-1:0]    id_q;
	logic [KIND_W-1:0]  kind_q;
	logic               hdr_q;

	// per-peer state
	logic [GAUGE_W-1:0] gauge_q     [NUM_PEERS];
	logic [TICK_W-1:0]  last_tick_q [NUM_PEERS];
	logic               tick_seen_q [NUM_PEERS];
	logic [ID_W-1:0]    last_seq_q  [NUM_PEERS];
	logic               seq_seen_q  [NUM_PEERS];
	logic [DUP_W-1:0]   dup_q       [NUM_PEERS];

	// stage one results
	logic [GAUGE_W-1:0] gauge_s1, amt_s1;
	op_t                op_s1;
	logic               dec_req_s1, seq_upd_s1, peer_ok_s1;

	logic [M_TDATA_W-1:0] out_q;

	logic [PEER_IDX_W-1:0] idx;
	logic                  peer_ok, inb_ok, eligible, dec_base;
	logic [ID_W-1:0]       last_seq, diff;
	logic                  gap, late, adv;
	logic [1:0]            run;
	logic [TICK_W-1:0]     dt;
	logic [GAUGE_W-1:0]    g_cur, g_dec, g_s1_nx, amt_nx;
	op_t                   op_nx;
	logic                  dec_req_nx, seq_upd_nx;

	logic [GAUGE_W:0]      sum;
	logic [GAUGE_W-1:0]    g_nx;
	logic                  go, dup_inc;
	logic [COPIES_W-1:0]   copies_nx;
	logic [DUP_W-1:0]      dup_nx;

	assign idx     = peer_q[PEER_IDX_W-1:0];
	assign peer_ok = !peer_q[PEER_W-1] &&
		({1'b0, peer_q[PEER_W-2:0]} < PEER_W'(NUM_PEERS));

	// stage one: classify and decay
	always_comb begin
		g_cur    = gauge_q[idx];
		last_seq = last_seq_q[idx];
		diff     = id_q - last_seq;
		gap      = seq_seen_q[idx] && (id_q > last_seq + 32'd1);
		late     = seq_seen_q[idx] && (id_q < last_seq);
		adv      = !seq_seen_q[idx] || (id_q > last_seq);
		run      = (diff > GAP_RUN_CAP) ? 2'd3 : (diff[1:0] - 2'd1);
		inb_ok   = cfg_enabled_q && !id_q[ID_W-1] && peer_ok;
		eligible = (kind_q == KIND_RELIABLE) || (cfg_dup_acks_q && kind_q == KIND_ACK);
		dec_base = cfg_enabled_q && hdr_q && cfg_copy_q[1] && eligible;

		op_nx      = OP_NONE;
		dec_req_nx = 1'b0;
		seq_upd_nx = 1'b0;
		amt_nx     = RESEND_BUMP;
		unique case (func_q)
			FUNC_RESEND: begin
				op_nx      = peer_ok ? OP_BUMP : OP_NONE;
				dec_req_nx = peer_ok;
			end
			FUNC_INBOUND: begin
				seq_upd_nx = inb_ok && adv;
				if (inb_ok && gap) begin
					op_nx      = OP_BUMP;
					dec_req_nx = 1'b1;
					amt_nx     = gap_amount(run);
				end else if (inb_ok && late) begin
					op_nx      = OP_REFUND;
					dec_req_nx = 1'b1;
				end
			end
			FUNC_DECIDE: begin
				op_nx      = dec_base ? OP_DECIDE : OP_NONE;
				dec_req_nx = dec_base && cfg_adaptive_q && peer_ok;
			end
			FUNC_NONE: op_nx = OP_NONE;
			default:   op_nx = OP_NONE;
		endcase

		dt = now_q - last_tick_q[idx];
		if (!tick_seen_q[idx])
			g_dec = g_cur;
		else if (dt >= TICK_W'(g_cur))
			g_dec = '0;
		else
			g_dec = g_cur - dt[GAUGE_W-1:0];
		g_s1_nx = dec_req_nx ? g_dec : g_cur;
	end

	// stage two: apply
	always_comb begin
		sum  = {1'b0, gauge_s1} + {1'b0, amt_s1};
		g_nx = gauge_s1;
		unique case (op_s1)
			OP_BUMP:   g_nx = (sum > {1'b0, GAUGE_CAP}) ? GAUGE_CAP : sum[GAUGE_W-1:0];
			OP_REFUND: g_nx = (gauge_s1 > GAP_BUMP) ? (gauge_s1 - GAP_BUMP) : '0;
			OP_DECIDE: g_nx = gauge_s1;
			OP_NONE:   g_nx = gauge_s1;
			default:   g_nx = gauge_s1;
		endcase
		go        = !cfg_adaptive_q || (peer_ok_s1 && gauge_s1 != '0);
		dup_inc   = (op_s1 == OP_DECIDE) && go && peer_ok_s1;
		copies_nx = ((op_s1 == OP_DECIDE) && go) ? COPIES_TWO : COPIES_ONE;
		dup_nx    = dup_q[idx] + DUP_W'(dup_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_enabled_q  <= 1'b1;
			cfg_copy_q     <= COPIES_TWO;
			cfg_adaptive_q <= 1'b1;
			cfg_dup_acks_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLED:    cfg_enabled_q  <= cfg_data[0];
				CFG_COPY_COUNT: cfg_copy_q     <= cfg_data[COPIES_W-1:0];
				CFG_ADAPTIVE:   cfg_adaptive_q <= cfg_data[0];
				CFG_DUP_ACKS:   cfg_dup_acks_q <= cfg_data[0];
				default:        cfg_enabled_q  <= cfg_enabled_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(in_func);
			peer_q <= in_data[3:0];
			now_q  <= in_data[35:4];
			id_q   <= in_data[67:36];
			kind_q <= in_data[69:68];
			hdr_q  <= in_data[70];
		end
		if (cmd.stage) begin
			gauge_s1   <= g_s1_nx;
			amt_s1     <= amt_nx;
			op_s1      <= op_nx;
			dec_req_s1 <= dec_req_nx;
			seq_upd_s1 <= seq_upd_nx;
			peer_ok_s1 <= peer_ok;
		end
		if (cmd.commit) begin
			out_q <= {7'b0, peer_ok_s1 ? dup_nx : {DUP_W{1'b0}},
				peer_ok_s1 ? g_nx : {GAUGE_W{1'b0}}, copies_nx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PEERS; i++) begin
				gauge_q[i]     <= '0;
				last_tick_q[i] <= '0;
				tick_seen_q[i] <= 1'b0;
				last_seq_q[i]  <= '0;
				seq_seen_q[i]  <= 1'b0;
				dup_q[i]       <= '0;
			end
		end else if (cmd.commit && peer_ok_s1) begin
			gauge_q[idx] <= g_nx;
			dup_q[idx]   <= dup_nx;
			if (dec_req_s1) begin
				last_tick_q[idx] <= now_q;
				tick_seen_q[idx] <= 1'b1;
			end
			if (seq_upd_s1) begin
				last_seq_q[idx] <= id_q;
				seq_seen_q[idx] <= 1'b1;
			end
		end
	end

	assign out_data = out_q;

`ifndef SYNTH
	a_gauge_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (g_nx <= GAUGE_CAP))
		else $error("gauge above cap");
	a_bad_peer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !peer_ok_s1) |=> (out_q[48:2] == '0))
		else $error("invalid peer reported non-zero state");
	a_single_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_s1 != OP_DECIDE) |=> (out_q[1:0] == COPIES_ONE))
		else $error("duplication outside a copy decision");
`endif

endmodule

`default_nettype wire

[sv/adaptive_packet_redundancy.sv]
// top level of the adaptive packet redundancy block
// instantiates apr_ctrl and apr_dp; depends on apr_pkg
//
//   channel  direction  handshake           payload
//   s_*      in         s_tvalid/s_tready   s_tuser func, s_tdata peer..header_complete
//   m_*      out        m_tvalid/m_tready   m_tdata copies, loss_level, dup_total
//   cfg_*    in         cfg_we              cfg_index, cfg_data
//
// each beat passes through capture, the decay stage, then apply and commit
// a new beat is taken only after the previous one commits, while the result register drains
// apply waits only when the previous result is still held and m_tready is low
// arst_n clears all peer state and loads the register defaults; no clearing pass
`default_nettype none

module adaptive_packet_redundancy (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// func
	input  wire logic [apr_pkg::FUNC_W-1:0]      s_tuser,
	// peer, now_ms, packet_id, packet_kind, header_complete, zero pad
	input  wire logic [apr_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// copies, loss_level, dup_total, zero pad
	output logic      [apr_pkg::M_TDATA_W-1:0]   m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [apr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [apr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import apr_pkg::*;

	apr_cmd_t cmd;

	apr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	apr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_func   (s_tuser),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire
